FILE: hw/rtl/c_sbc_pkg.sv
// Shared types and byte constants for the C syntax balance checker.
// No dependencies; imported by every module of the block.
package c_sbc_pkg;

	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} src_word_t;

	typedef struct packed {
		logic pass;
		logic paren_mismatch;
		logic brace_mismatch;
		logic bracket_mismatch;
		logic open_literal;
		logic open_comment;
		logic count_overflow;
	} res_word_t;

	typedef struct packed {
		logic in_single_quote;
		logic in_double_quote;
		logic in_line_comment;
		logic in_block_comment;
		logic escape_pending;
		logic slash_pending;
		logic star_pending;
	} scan_state_t;

	typedef struct packed {
		logic up;
		logic down;
	} bump_t;

	typedef struct packed {
		bump_t paren;
		bump_t brace;
		bump_t bracket;
	} bump_req_t;

endpackage

FILE: hw/rtl/c_sbc_scan.sv
// Lexical scanner: next literal/comment state and counter requests for one byte.
// Depends on c_sbc_pkg.
module c_sbc_scan (
	input  logic [7:0]           ch,
	input  c_sbc_pkg::scan_state_t cur,
	output c_sbc_pkg::scan_state_t nxt,
	output c_sbc_pkg::bump_req_t   req
);
	import c_sbc_pkg::*;

	logic done;

	always_comb begin
		nxt  = cur;
		req  = '0;
		done = 1'b0;

		// The byte after a backslash inside a literal is swallowed.
		if (cur.escape_pending) begin
			nxt.escape_pending = 1'b0;
			done = 1'b1;
		end

		// A pending slash either opens a comment or falls through as a normal byte.
		if (!done && cur.slash_pending) begin
			nxt.slash_pending = 1'b0;
			if (ch == CH_SLASH) begin
				nxt.in_line_comment = 1'b1;
				done = 1'b1;
			end else if (ch == CH_STAR) begin
				nxt.in_block_comment = 1'b1;
				done = 1'b1;
			end
		end

		if (!done && cur.star_pending) begin
			nxt.star_pending = 1'b0;
			if (ch == CH_SLASH) begin
				nxt.in_block_comment = 1'b0;
				done = 1'b1;
			end
		end

		if (!done && nxt.in_block_comment) begin
			if (ch == CH_STAR) nxt.star_pending = 1'b1;
			done = 1'b1;
		end

		if (!done && nxt.in_line_comment) begin
			if (ch == CH_NEWLINE) nxt.in_line_comment = 1'b0;
			done = 1'b1;
		end

		if (!done && nxt.in_single_quote) begin
			if (ch == CH_BSLASH) nxt.escape_pending = 1'b1;
			else if (ch == CH_SQUOTE) nxt.in_single_quote = 1'b0;
			done = 1'b1;
		end

		if (!done && nxt.in_double_quote) begin
			if (ch == CH_BSLASH) nxt.escape_pending = 1'b1;
			else if (ch == CH_DQUOTE) nxt.in_double_quote = 1'b0;
			done = 1'b1;
		end

		if (!done) begin
			unique case (ch)
				CH_SQUOTE: nxt.in_single_quote = 1'b1;
				CH_DQUOTE: nxt.in_double_quote = 1'b1;
				CH_SLASH:  nxt.slash_pending   = 1'b1;
				CH_LPAREN: req.paren.up        = 1'b1;
				CH_RPAREN: req.paren.down      = 1'b1;
				CH_LBRACE: req.brace.up        = 1'b1;
				CH_RBRACE: req.brace.down      = 1'b1;
				CH_LBRACK: req.bracket.up      = 1'b1;
				CH_RBRACK: req.bracket.down    = 1'b1;
				default: ;
			endcase
		end
	end

endmodule

FILE: hw/rtl/c_sbc_counter.sv
// Saturating signed net counter for one bracket kind.
// Depends on c_sbc_pkg for the request type.
module c_sbc_counter #(
	parameter int COUNT_WIDTH = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             clr,
	input  c_sbc_pkg::bump_t bump,
	output logic             nonzero,
	output logic             sat
);
	import c_sbc_pkg::*;

	localparam logic signed [COUNT_WIDTH-1:0] NetMax = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] NetMin = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	logic signed [COUNT_WIDTH-1:0] net_q;
	logic signed [COUNT_WIDTH-1:0] net_d;

	always_comb begin
		net_d = net_q;
		sat   = 1'b0;
		if (bump.up) begin
			if (net_q == NetMax) sat = 1'b1;
			else net_d = net_q + 1'b1;
		end else if (bump.down) begin
			if (net_q == NetMin) sat = 1'b1;
			else net_d = net_q - 1'b1;
		end
	end

	// The verdict looks at the count after the current byte.
	assign nonzero = (net_d != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_q <= '0;
		end else if (en) begin
			if (clr) net_q <= '0;
			else net_q <= net_d;
		end
	end

endmodule

FILE: hw/rtl/c_syntax_balance_checker.sv
// C source balance checker: scans one byte per cycle for (), {}, [] balance,
// quoted literals and comments. Throughput is one byte per clock while no
// last-marked byte waits. A byte is registered on accept and scanned the next cycle;
// the verdict for a last-marked byte is then registered in the result register. A
// last-marked byte waits in the input register only while an earlier verdict has
// not been taken. Reset (arst_n low) clears all scan state, counters and both
// word valid flags; scan state and counters also clear after every last-marked byte.
module c_syntax_balance_checker #(
	parameter int COUNT_WIDTH = 17
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   src_valid,
	output logic                   src_ready,
	input  c_sbc_pkg::src_word_t   src_data,
	output logic                   res_valid,
	input  logic                   res_ready,
	output c_sbc_pkg::res_word_t   res_data
);
	import c_sbc_pkg::*;

	src_word_t   word_s1;
	logic        valid_s1;
	logic        advance;
	scan_state_t state_q;
	scan_state_t state_d;
	bump_req_t   req;
	logic        overflow_q;
	logic        paren_nz, brace_nz, bracket_nz;
	logic        paren_sat, brace_sat, bracket_sat;
	logic        ovf_now;
	logic        open_lit, open_cmt, any_mismatch;
	logic        res_valid_q;
	res_word_t   res_q;

	// A non-last word never waits; a last word waits only for a free result slot.
	assign advance   = valid_s1 && (!word_s1.last || !res_valid_q || res_ready);
	assign src_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) word_s1 <= src_data;
	end

	c_sbc_scan u_scan (
		.ch  (word_s1.ch),
		.cur (state_q),
		.nxt (state_d),
		.req (req)
	);

	c_sbc_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_paren (
		.clk, .arst_n, .en(advance), .clr(word_s1.last),
		.bump(req.paren), .nonzero(paren_nz), .sat(paren_sat)
	);

	c_sbc_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_brace (
		.clk, .arst_n, .en(advance), .clr(word_s1.last),
		.bump(req.brace), .nonzero(brace_nz), .sat(brace_sat)
	);

	c_sbc_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_bracket (
		.clk, .arst_n, .en(advance), .clr(word_s1.last),
		.bump(req.bracket), .nonzero(bracket_nz), .sat(bracket_sat)
	);

	assign ovf_now      = overflow_q || paren_sat || brace_sat || bracket_sat;
	assign open_lit     = state_d.in_single_quote || state_d.in_double_quote;
	assign open_cmt     = state_d.in_line_comment || state_d.in_block_comment;
	assign any_mismatch = paren_nz || brace_nz || bracket_nz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= '0;
			overflow_q <= 1'b0;
		end else if (advance) begin
			if (word_s1.last) begin
				state_q    <= '0;
				overflow_q <= 1'b0;
			end else begin
				state_q    <= state_d;
				overflow_q <= ovf_now;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && word_s1.last) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && word_s1.last) begin
			res_q.pass             <= !(any_mismatch || open_lit || open_cmt || ovf_now);
			res_q.paren_mismatch   <= paren_nz;
			res_q.brace_mismatch   <= brace_nz;
			res_q.bracket_mismatch <= bracket_nz;
			res_q.open_literal     <= open_lit;
			res_q.open_comment     <= open_cmt;
			res_q.count_overflow   <= ovf_now;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule
